### design/assert_macros.svh
// Assertion macros used by the checker file bcdac_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge, suspended while reset is low.
`define BCDAC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define BCDAC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/bcdac_pkg.sv
// Shared types and codes of the BCD 12-hour alarm clock.
package bcdac_pkg;

  localparam int TICKS_W = 16;
  localparam int HOLD_W  = 24;
  localparam int ACT_W   = 3;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd60;
  localparam logic [HOLD_W-1:0]  SNOOZE_RESET = 24'd500000;

  localparam logic [ACT_W-1:0] ACT_TICK       = 3'd0;
  localparam logic [ACT_W-1:0] ACT_TIME_UP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TIME_DOWN  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_ALARM_UP   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ALARM_DOWN = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SELECT     = 3'd5;

  localparam logic CFG_TICKS  = 1'b0;
  localparam logic CFG_SNOOZE = 1'b1;

  typedef struct packed {
    logic       ht;
    logic [3:0] ho;
    logic [2:0] mt;
    logic [3:0] mo;
    logic       pm;
  } bcd_time_t;

  localparam bcd_time_t TIME_RESET = '{ht: 1'b1, ho: 4'd2, mt: 3'd0, mo: 4'd0, pm: 1'b0};

  typedef enum logic [1:0] {
    STEP_HOLD,
    STEP_UP,
    STEP_DOWN,
    STEP_SNOOZE
  } step_op_t;

  typedef struct packed {
    bcd_time_t clk_time;
    bcd_time_t wake_time;
    logic      ringing;
    logic      armed;
  } clock_state_t;

endpackage

### design/bcd_twelve_hour_alarm_clock_top.sv
// Top level of the BCD 12-hour alarm clock: input word register, core, result register.
// A word waits in the input register until the result register can take its result.
// One word per cycle while out_ready holds; the clock and alarm step combinationally.
// Reset (rst_n low, synchronous): 12:00 AM on both times, alarm disarmed and silent,
// tick count 0, ticks_per_minute 60, snooze threshold 500000, both stages empty.
module bcd_twelve_hour_alarm_clock_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bcdac_pkg::HOLD_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bcdac_pkg::ACT_W-1:0]   in_action,
  input  logic [bcdac_pkg::HOLD_W-1:0]  in_hold_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_time_hour_tens,
  output logic [3:0]                    out_time_hour_ones,
  output logic [2:0]                    out_time_minute_tens,
  output logic [3:0]                    out_time_minute_ones,
  output logic                          out_time_is_pm,
  output logic                          out_alarm_hour_tens,
  output logic [3:0]                    out_alarm_hour_ones,
  output logic [2:0]                    out_alarm_minute_tens,
  output logic [3:0]                    out_alarm_minute_ones,
  output logic                          out_alarm_is_pm,
  output logic                          out_ringing,
  output logic                          out_armed
);
  import bcdac_pkg::*;

  logic              s1_valid_r;
  logic [ACT_W-1:0]  s1_action_r;
  logic [HOLD_W-1:0] s1_hold_r;
  logic              out_valid_r;
  clock_state_t      res_r;
  clock_state_t      res_nxt;
  logic              advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  bcdac_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .go          (advance),
    .action      (s1_action_r),
    .hold_length (s1_hold_r),
    .state_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action_r <= in_action;
      s1_hold_r   <= in_hold_length;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_time_hour_tens    = res_r.clk_time.ht;
  assign out_time_hour_ones    = res_r.clk_time.ho;
  assign out_time_minute_tens  = res_r.clk_time.mt;
  assign out_time_minute_ones  = res_r.clk_time.mo;
  assign out_time_is_pm        = res_r.clk_time.pm;
  assign out_alarm_hour_tens   = res_r.wake_time.ht;
  assign out_alarm_hour_ones   = res_r.wake_time.ho;
  assign out_alarm_minute_tens = res_r.wake_time.mt;
  assign out_alarm_minute_ones = res_r.wake_time.mo;
  assign out_alarm_is_pm       = res_r.wake_time.pm;
  assign out_ringing           = res_r.ringing;
  assign out_armed             = res_r.armed;

endmodule

### design/bcdac_step.sv
// One-minute up/down and five-minute snooze step of a BCD 12-hour time.
module bcdac_step (
  input  bcdac_pkg::bcd_time_t cur,
  input  bcdac_pkg::step_op_t  op,
  output bcdac_pkg::bcd_time_t nxt
);
  import bcdac_pkg::*;

  function automatic bcd_time_t hour_inc(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (!t.ht && t.ho == 4'd9) begin
      r.ht = 1'b1;
      r.ho = 4'd0;
    end else if (t.ht && t.ho == 4'd1) begin
      r.ho = 4'd2;
      r.pm = ~t.pm;
    end else if (t.ht && t.ho == 4'd2) begin
      r.ht = 1'b0;
      r.ho = 4'd1;
    end else begin
      r.ho = t.ho + 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t hour_dec(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.ht && t.ho == 4'd2) begin
      r.ho = 4'd1;
      r.pm = ~t.pm;
    end else if (!t.ht && t.ho == 4'd1) begin
      r.ht = 1'b1;
      r.ho = 4'd2;
    end else if (t.ht && t.ho == 4'd0) begin
      r.ht = 1'b0;
      r.ho = 4'd9;
    end else begin
      r.ho = t.ho - 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t tens_carry(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mt == 3'd5) begin
      r    = hour_inc(t);
      r.mt = 3'd0;
    end else begin
      r.mt = t.mt + 3'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t step_up(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mo == 4'd9) begin
      r    = tens_carry(t);
      r.mo = 4'd0;
    end else begin
      r.mo = t.mo + 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t step_down(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mo != 4'd0) begin
      r.mo = t.mo - 4'd1;
    end else if (t.mt != 3'd0) begin
      r.mo = 4'd9;
      r.mt = t.mt - 3'd1;
    end else begin
      r    = hour_dec(t);
      r.mo = 4'd9;
      r.mt = 3'd5;
    end
    return r;
  endfunction

  function automatic bcd_time_t add_five(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.mo >= 4'd5) begin
      r    = tens_carry(t);
      r.mo = t.mo - 4'd5;
    end else begin
      r.mo = t.mo + 4'd5;
    end
    return r;
  endfunction

  always_comb begin
    case (op)
      STEP_UP:     nxt = step_up(cur);
      STEP_DOWN:   nxt = step_down(cur);
      STEP_SNOOZE: nxt = add_five(cur);
      default:     nxt = cur;
    endcase
  end

endmodule

### design/bcdac_core.sv
// Clock, alarm, tick counter and ringing state with their next-state logic.
module bcdac_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [bcdac_pkg::HOLD_W-1:0]   cfg_wdata,
  input  logic                           go,
  input  logic [bcdac_pkg::ACT_W-1:0]    action,
  input  logic [bcdac_pkg::HOLD_W-1:0]   hold_length,
  output bcdac_pkg::clock_state_t        state_nxt
);
  import bcdac_pkg::*;

  logic [TICKS_W-1:0] ticks_per_min_r;
  logic [HOLD_W-1:0]  snooze_thr_r;
  logic [TICKS_W-1:0] tick_count_r;
  logic [TICKS_W-1:0] tick_count_nxt;
  clock_state_t       state_r;

  logic [TICKS_W:0]   tick_inc;
  logic               tick_wrap;
  step_op_t           clk_op;
  step_op_t           wake_op;
  bcd_time_t          clk_nxt;
  bcd_time_t          wake_nxt;
  logic               armed_nxt;
  logic               ring_keep;
  logic               match_before;
  logic               match_after;

  assign tick_inc     = {1'b0, tick_count_r} + {{TICKS_W{1'b0}}, 1'b1};
  assign tick_wrap    = tick_inc >= {1'b0, ticks_per_min_r};
  assign match_before = state_r.armed && (state_r.clk_time == state_r.wake_time);

  always_comb begin
    clk_op         = STEP_HOLD;
    wake_op        = STEP_HOLD;
    tick_count_nxt = tick_count_r;
    armed_nxt      = state_r.armed;
    ring_keep      = state_r.ringing;
    case (action)
      ACT_TICK: begin
        if (tick_wrap) begin
          clk_op         = STEP_UP;
          tick_count_nxt = '0;
        end else begin
          tick_count_nxt = tick_inc[TICKS_W-1:0];
        end
      end
      ACT_TIME_UP:   clk_op = STEP_UP;
      ACT_TIME_DOWN: clk_op = STEP_DOWN;
      ACT_ALARM_UP: begin
        wake_op   = STEP_UP;
        armed_nxt = 1'b1;
      end
      ACT_ALARM_DOWN: begin
        wake_op   = STEP_DOWN;
        armed_nxt = 1'b1;
      end
      ACT_SELECT: begin
        ring_keep = 1'b0;
        if (state_r.ringing && hold_length > snooze_thr_r) begin
          wake_op = STEP_SNOOZE;
        end
      end
      default: ;
    endcase
  end

  bcdac_step u_clk_step (
    .cur (state_r.clk_time),
    .op  (clk_op),
    .nxt (clk_nxt)
  );

  bcdac_step u_wake_step (
    .cur (state_r.wake_time),
    .op  (wake_op),
    .nxt (wake_nxt)
  );

  assign match_after = armed_nxt && (clk_nxt == wake_nxt);

  always_comb begin
    state_nxt.clk_time  = clk_nxt;
    state_nxt.wake_time = wake_nxt;
    state_nxt.armed     = armed_nxt;
    state_nxt.ringing   = ring_keep || (match_after && !match_before);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_min_r <= TICKS_RESET;
      snooze_thr_r    <= SNOOZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS:  ticks_per_min_r <= cfg_wdata[TICKS_W-1:0];
        CFG_SNOOZE: snooze_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r        <= '0;
      state_r.clk_time    <= TIME_RESET;
      state_r.wake_time   <= TIME_RESET;
      state_r.ringing     <= 1'b0;
      state_r.armed       <= 1'b0;
    end else if (go) begin
      tick_count_r <= tick_count_nxt;
      state_r      <= state_nxt;
    end
  end

endmodule

### design/bcdac_checker.sv
// Port-level checks of the alarm clock top level and their bind.
`include "assert_macros.svh"

module bcdac_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_time_hour_tens,
  input logic [3:0] out_time_hour_ones,
  input logic [2:0] out_time_minute_tens,
  input logic [3:0] out_time_minute_ones,
  input logic       out_ringing,
  input logic       out_armed
);

  `BCDAC_ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> !out_valid, "result valid after reset")

  `BCDAC_ASSERT(a_hold_stalled, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_ringing) && $stable(out_time_minute_ones), "stalled result changed")

  `BCDAC_ASSERT(a_ring_needs_arm, clk, rst_n, out_valid |-> !out_ringing || out_armed, "ringing while disarmed")

  `BCDAC_ASSERT(a_time_in_range, clk, rst_n, out_valid |-> out_time_minute_ones <= 4'd9 && out_time_minute_tens <= 3'd5 && ((!out_time_hour_tens && out_time_hour_ones != 4'd0 && out_time_hour_ones <= 4'd9) || (out_time_hour_tens && out_time_hour_ones <= 4'd2)), "clock time out of range")

endmodule

bind bcd_twelve_hour_alarm_clock_top bcdac_checker u_bcdac_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_time_hour_tens   (out_time_hour_tens),
  .out_time_hour_ones   (out_time_hour_ones),
  .out_time_minute_tens (out_time_minute_tens),
  .out_time_minute_ones (out_time_minute_ones),
  .out_ringing          (out_ringing),
  .out_armed            (out_armed)
);
